@@ hdl/lpht_pkg.sv @@
// Shared types and constants for the linear-probe hash table.
package lpht_pkg;

  // Slot count; the home slot is the low bits of the key, so a power of two.
  localparam int unsigned TABLE_SIZE = 16;
  localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned IDX_W      = 4;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StAbsent = 2'd1,
    StFull   = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key_value;
  } in_word_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] slot_index;
  } out_word_t;

  // Controller to key memory.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  // Controller to result register.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

@@ hdl/lpht_key_ram.sv @@
// Key store: one write port, one read port, registered read data.
module lpht_key_ram (
  input  logic                          clk_i,
  input  lpht_pkg::ram_req_t            req_i,
  output logic [lpht_pkg::KEY_W-1:0]    rdata_o
);

  logic [lpht_pkg::KEY_W-1:0] mem_q [lpht_pkg::TABLE_SIZE];
  logic [lpht_pkg::KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lpht_ctrl.sv @@
// Probe sequencer: walks slots from home, owns the valid bits.
module lpht_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lpht_pkg::in_word_t            in_word_i,
  output lpht_pkg::ram_req_t            ram_req_o,
  input  logic [lpht_pkg::KEY_W-1:0]    ram_rdata_i,
  output lpht_pkg::res_t                res_o,
  input  logic                          res_ready_i
);

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StProbe = 2'b10
  } state_e;

  localparam logic [lpht_pkg::SLOT_W-1:0] LastSlot =
    lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SIZE - 1);

  state_e                              state_q, state_d;
  logic [lpht_pkg::SLOT_W-1:0]         slot_q, slot_d;
  logic [lpht_pkg::SLOT_W-1:0]         cnt_q, cnt_d;
  logic [lpht_pkg::TABLE_SIZE-1:0]     valid_q, valid_d;
  logic [1:0]                          mode_q, mode_d;
  logic [lpht_pkg::KEY_W-1:0]          key_q, key_d;

  logic is_ins, is_srch, is_del, hit, finish;

  always_comb begin
    is_ins  = (mode_q == lpht_pkg::MODE_INSERT);
    is_srch = (mode_q == lpht_pkg::MODE_SEARCH);
    is_del  = (mode_q == lpht_pkg::MODE_DELETE);
    // insert wants a free slot; search/delete want a live matching key
    if (is_ins) begin
      hit = !valid_q[slot_q];
    end else if (is_srch || is_del) begin
      hit = valid_q[slot_q] && (ram_rdata_i == key_q);
    end else begin
      hit = 1'b0;
    end
    finish = hit || (cnt_q == LastSlot) || !(is_ins || is_srch || is_del);
  end

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    mode_d  = mode_q;
    key_d   = key_q;

    in_ready_o = 1'b0;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = slot_q;
    ram_req_o.wdata = key_q;

    res_o.valid           = 1'b0;
    res_o.word.status     = lpht_pkg::StAbsent;
    res_o.word.slot_index = '0;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d  = in_word_i.mode;
          key_d   = in_word_i.key_value;
          slot_d  = in_word_i.key_value[lpht_pkg::SLOT_W-1:0];
          cnt_d   = '0;
          state_d = StProbe;
        end
      end
      StProbe: begin
        if (finish) begin
          res_o.valid = 1'b1;
          if (hit) begin
            res_o.word.status     = lpht_pkg::StOk;
            res_o.word.slot_index = lpht_pkg::IDX_W'(slot_q);
          end else if (is_ins) begin
            res_o.word.status = lpht_pkg::StFull;
          end
          // commit only once the result register takes the word
          if (res_ready_i) begin
            state_d = StIdle;
            if (hit && is_ins) begin
              ram_req_o.we    = 1'b1;
              valid_d[slot_q] = 1'b1;
            end else if (hit && is_del) begin
              valid_d[slot_q] = 1'b0;
            end
          end
        end else begin
          slot_d = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // read address follows the next slot, so the registered read data lines up with slot_q
    ram_req_o.raddr = slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      slot_q  <= '0;
      cnt_q   <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    key_q  <= key_d;
  end

endmodule

@@ hdl/linear_probe_hash_table_core.sv @@
// Top level of the linear-probe hash table: controller, key store, result register.
//
// Open-addressing hash table of lpht_pkg::TABLE_SIZE slots (16). Each input word
// carries a mode (insert, search, delete) and a 31-bit key; each produces exactly
// one output word with a status and a slot index. The home slot is the low bits
// of the key; probing walks forward one slot per cycle with wraparound, visiting
// every slot at most once. Insert takes the first free slot (duplicates allowed),
// search and delete take the first live matching slot and skip over free ones;
// delete frees it. A full table reports status full, a missing key or an unused
// mode reports not found, both with slot index zero. The word is registered into
// the controller before probing starts; the limit on the probe rate is the single
// read port of the key memory, which delivers one slot per cycle. One word is in
// the probe at a time. A finished result sits in an output register, so the next
// word is taken while it waits. Valid bits are flip-flops cleared by reset; no
// clearing pass is needed.
module linear_probe_hash_table_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lpht_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lpht_pkg::out_word_t  out_word_o
);

  lpht_pkg::ram_req_t             ram_req;
  logic [lpht_pkg::KEY_W-1:0]     ram_rdata;
  lpht_pkg::res_t                 res;
  logic                           res_ready;

  logic                           out_valid_q, out_valid_d;
  lpht_pkg::out_word_t            out_word_q;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .ram_req_o  (ram_req),
    .ram_rdata_i(ram_rdata),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  lpht_key_ram u_key_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(ram_rdata)
  );

  // result register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_word_q <= res.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ hdl/lpht_checker.sv @@
// Port-level checks for the hash table core, bound to the top level.
module lpht_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_o,
  input  lpht_pkg::in_word_t   in_word_i,
  input  logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lpht_pkg::out_word_t  out_word_o
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result changed while stalled");

  // failure statuses carry slot zero
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != lpht_pkg::StOk) |-> out_word_o.slot_index == '0)
    else $error("nonzero slot on failed operation");

  // every result belongs to an accepted word
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result without a pending word");

  // at most one word probing plus one result waiting
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (pend_q != 2'd2) || out_acc)
    else $error("too many words in flight");

  // after reset no result is waiting
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the linear-probe hash table core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  // Mode 3 has no package code; the core must answer it as a miss.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned RANDOM_WORDS = 1425;
  localparam int unsigned PHASE_LEN    = 120;
  // Longest quiet stretch in a correct run is a long input gap plus a long
  // output stall plus a full probe; allow far more.
  localparam int unsigned IDLE_LIMIT   = 2000;

  // One row of the directed table: the word to send and, where it is plain
  // from the table contents, the reply typed in by hand.
  typedef struct {
    in_word_t  word;
    bit        fixed;
    out_word_t want;
  } step_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  // Shadow copy of the table, updated as each word is accepted.
  logic [KEY_W-1:0] slot_key  [TABLE_SIZE];
  logic             slot_live [TABLE_SIZE];
  logic [KEY_W-1:0] freed_key = '0;

  // Replies owed by the core, oldest first.
  out_word_t reply_q [$];
  step_row_t rows [$];

  int unsigned errors    = 0;
  int unsigned n_insert  = 0;
  int unsigned n_search  = 0;
  int unsigned n_delete  = 0;
  int unsigned n_unused  = 0;
  int unsigned n_full    = 0;
  int unsigned n_miss    = 0;
  int unsigned n_replies = 0;

  // Set per phase: no idling on either side while it is high.
  bit calm = 1'b0;
  int unsigned out_stall = 0;

  linear_probe_hash_table_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one word to the shadow table and return the reply it causes.
  // Probes run from the home slot with wraparound, each slot at most once.
  function automatic out_word_t table_apply(input in_word_t w);
    out_word_t   r;
    int unsigned home;
    int unsigned s;
    bit          hit;
    r.status     = StAbsent;
    r.slot_index = '0;
    hit          = 1'b0;
    home         = w.key_value % TABLE_SIZE;
    case (w.mode)
      MODE_INSERT: begin
        n_insert++;
        // First free slot wins; duplicates are fine.
        for (int i = 0; i < TABLE_SIZE && !hit; i++) begin
          s = (home + i) % TABLE_SIZE;
          if (!slot_live[s]) begin
            slot_key[s]  = w.key_value;
            slot_live[s] = 1'b1;
            r.status     = StOk;
            r.slot_index = s[IDX_W-1:0];
            hit          = 1'b1;
          end
        end
        if (!hit) begin
          r.status = StFull;
          n_full++;
        end
      end
      MODE_SEARCH, MODE_DELETE: begin
        if (w.mode == MODE_SEARCH) n_search++;
        else n_delete++;
        // Free slots are passed over, not treated as end of chain.
        for (int i = 0; i < TABLE_SIZE && !hit; i++) begin
          s = (home + i) % TABLE_SIZE;
          if (slot_live[s] && slot_key[s] == w.key_value) begin
            r.status     = StOk;
            r.slot_index = s[IDX_W-1:0];
            hit          = 1'b1;
            if (w.mode == MODE_DELETE) begin
              slot_live[s] = 1'b0;
              freed_key    = w.key_value;
            end
          end
        end
        if (!hit) n_miss++;
      end
      default: begin
        n_unused++;
      end
    endcase
    return r;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Key picker: live keys for hits and duplicates, a recently freed key to
  // check that stale memory contents are ignored, clustered homes for long
  // probe chains and wraparound, plus fully random and extreme values.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [31:0] k;
    int unsigned r;
    int unsigned start;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      start = $urandom_range(0, TABLE_SIZE - 1);
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (slot_live[(start + i) % TABLE_SIZE]) return slot_key[(start + i) % TABLE_SIZE];
      end
    end
    if (r < 58) return freed_key;
    if (r < 80) begin
      k      = $urandom;
      k[3:0] = 4'($urandom_range(0, 3));
      return k[KEY_W-1:0];
    end
    if (r < 92) begin
      k = $urandom;
      return k[KEY_W-1:0];
    end
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return {{(KEY_W-4){1'b1}}, 4'h0};
      default: return 31'd15;
    endcase
  endfunction

  // Present one word, hold it until taken, then log the reply it owes.
  // A zero gap leaves valid high so the next word follows back to back.
  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t want);
    out_word_t   guess;
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    guess = table_apply(w);
    reply_q.push_back(fixed ? want : guess);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic add_row(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                         input bit fixed, input status_e st, input logic [IDX_W-1:0] idx);
    step_row_t row;
    row.word.mode       = mode;
    row.word.key_value  = key;
    row.fixed           = fixed;
    row.want.status     = st;
    row.want.slot_index = idx;
    rows.push_back(row);
  endtask

  // Reply side: check each taken word against the oldest owed reply, then
  // choose ready for the next cycle (random stalls unless calm).
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_replies++;
      if (reply_q.size() == 0) begin
        report("unexpected reply word", out_word_o, 0);
      end else begin
        if (out_word_o.status !== reply_q[0].status)
          report("status", out_word_o.status, reply_q[0].status);
        if (out_word_o.slot_index !== reply_q[0].slot_index)
          report("slot_index", out_word_o.slot_index, reply_q[0].slot_index);
        void'(reply_q.pop_front());
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      out_stall = pick_gap();
      out_ready_i <= (out_stall == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: give up once neither channel has moved a word for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_word_t    w;
    int unsigned n_random;
    int unsigned bias;
    int unsigned r;
    logic [1:0]  mode;

    for (int i = 0; i < TABLE_SIZE; i++) begin
      slot_key[i]  = '0;
      slot_live[i] = 1'b0;
    end

    // Directed table. The first sixteen inserts fill every slot, so every
    // key memory entry holds a written value before any full-length probe.
    add_row(MODE_INSERT, 31'd0,          1'b1, StOk,     4'd0);   // empty table, home 0
    add_row(MODE_INSERT, 31'h7FFF_FFFF,  1'b1, StOk,     4'd15);  // largest key, home 15
    add_row(MODE_INSERT, 31'd15,         1'b0, StOk,     4'd0);   // home 15 taken, wraps
    add_row(MODE_INSERT, 31'd16,         1'b0, StOk,     4'd0);   // collides at home 0
    add_row(MODE_INSERT, 31'd0,          1'b0, StOk,     4'd0);   // duplicate value
    add_row(MODE_INSERT, 31'd3,          1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'd3,          1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'd100,        1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'h4000_0000,  1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'h2AAA_AAAA,  1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'h5555_5555,  1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'd7,          1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'd8,          1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'd9,          1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'd10,         1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'd11,         1'b0, StOk,     4'd0);
    add_row(MODE_INSERT, 31'd42,         1'b1, StFull,   4'd0);   // table full
    add_row(MODE_SEARCH, 31'h7FFF_FFFF,  1'b1, StOk,     4'd15);
    add_row(MODE_SEARCH, 31'd0,          1'b1, StOk,     4'd0);   // first of two copies
    add_row(MODE_SEARCH, 31'd12345,      1'b1, StAbsent, 4'd0);   // absent, full probe
    add_row(MODE_UNUSED, 31'd0,          1'b1, StAbsent, 4'd0);   // unused mode
    add_row(MODE_DELETE, 31'd0,          1'b1, StOk,     4'd0);
    add_row(MODE_SEARCH, 31'd0,          1'b0, StOk,     4'd0);   // second copy found
    add_row(MODE_DELETE, 31'd99,         1'b1, StAbsent, 4'd0);   // delete of absent value
    add_row(MODE_INSERT, 31'd32,         1'b1, StOk,     4'd0);   // refills the freed slot

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].word, rows[i].fixed, rows[i].want);

    // Random part in phases: insert-heavy phases drive the table to full,
    // delete-heavy ones drain it, balanced ones churn in between.
    n_random = 0;
    bias     = 2;
    while (n_random < RANDOM_WORDS) begin
      if (n_random % PHASE_LEN == 0) begin
        bias = $urandom_range(0, 2);
        calm = ($urandom_range(0, 4) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        mode = MODE_UNUSED;
      end else begin
        r = $urandom_range(0, 99);
        case (bias)
          0:       mode = (r < 65) ? MODE_INSERT : (r < 85) ? MODE_SEARCH : MODE_DELETE;
          1:       mode = (r < 15) ? MODE_INSERT : (r < 35) ? MODE_SEARCH : MODE_DELETE;
          default: mode = (r < 35) ? MODE_INSERT : (r < 70) ? MODE_SEARCH : MODE_DELETE;
        endcase
      end
      w.mode      = mode;
      w.key_value = pick_key();
      send_word(w, 1'b0, '0);
      n_random++;
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    // Drain, then leave room for a full probe to catch any stray reply.
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (TABLE_SIZE + 4) @(posedge clk_i);

    $display("covered %0d replies: %0d insert, %0d search, %0d delete, %0d unused-mode words",
             n_replies, n_insert, n_search, n_delete, n_unused);
    $display("table-full replies %0d, not-found replies %0d, mismatches %0d",
             n_full, n_miss, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lpht_pkg.sv
hdl/lpht_key_ram.sv
hdl/lpht_ctrl.sv
hdl/linear_probe_hash_table_core.sv
hdl/lpht_checker.sv
sim/testbench.sv
